>>> rtl/core/circle_in_rotated_rect_test_macros.svh
// Assertion macros shared by the circle-in-rectangle checker
`ifndef CIRCLE_IN_ROTATED_RECT_TEST_MACROS_SVH
`define CIRCLE_IN_ROTATED_RECT_TEST_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define CIRT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CIRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/cirt_pkg.sv
// Types, constants and tables for the circle-in-rotated-rectangle test
package cirt_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;

    localparam int COORD_W  = 16;
    localparam int HALF_W   = 15;
    localparam int FRAC_W   = 8;
    localparam int XY_W     = 28;
    localparam int Z_W      = 32;
    localparam int GAIN_W   = 31;
    localparam int GAIN_SH  = 30;
    localparam int PROD_W   = XY_W + GAIN_W;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RADIUS = 8'd2;

    localparam logic [HALF_W-1:0] RADIUS_RESET = 15'd400;

    localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;

    localparam logic [Z_W-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic                   bypass;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [HALF_W-1:0]      half_width;
        logic [HALF_W-1:0]      half_height;
    } rot_stage_t;

endpackage

>>> rtl/core/cirt_cordic_stage.sv
// One registered CORDIC micro-rotation with its own valid/ready hold
module cirt_cordic_stage
    import cirt_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  rot_stage_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output rot_stage_t out_data
);

    logic                   valid_reg;
    rot_stage_t             data_reg;
    rot_stage_t             data_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  atan_step;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign dx        = in_data.y >>> STEP;
    assign dy        = in_data.x >>> STEP;
    assign atan_step = $signed(ATAN_TABLE[STEP]);

    always_comb
    begin
        data_next = in_data;
        if (!in_data.bypass)
        begin
            if (in_data.z >= 0)
            begin
                data_next.x = in_data.x - dx;
                data_next.y = in_data.y + dy;
                data_next.z = in_data.z - atan_step;
            end
            else
            begin
                data_next.x = in_data.x + dx;
                data_next.y = in_data.y - dy;
                data_next.z = in_data.z + atan_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/core/circle_in_rotated_rect_test.sv
// Top level of the circle-in-rotated-rectangle test pipeline
//
// Takes one query per clock while the output is not stalled and returns one
// flag per query, in order. The path runs through one input stage (offset and
// half-turn fold), one stage per CORDIC micro-rotation (min(CORDIC_STEPS, 24)
// of them), then gain multiply, rounding, magnitude and the final compare. Each
// stage holds its own valid bit, so bubbles close up while the output stalls.
// The target registers may be written at any time the pipeline is empty; each
// write is taken in the cycle it is offered.
module circle_in_rotated_rect_test
    import cirt_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // rect_x, rect_y, rect_angle, half_width, half_height, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // fully_inside, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int NUM_STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    logic signed [COORD_W-1:0] target_x_reg;
    logic signed [COORD_W-1:0] target_y_reg;
    logic [HALF_W-1:0]         target_radius_reg;

    logic signed [COORD_W-1:0] rect_x;
    logic signed [COORD_W-1:0] rect_y;
    logic [COORD_W-1:0]        rect_angle;
    logic [HALF_W-1:0]         half_width;
    logic [HALF_W-1:0]         half_height;

    logic signed [COORD_W-1:0] theta;
    logic                      fold;
    logic [COORD_W-1:0]        z_top;
    logic signed [COORD_W:0]   diff_x;
    logic signed [COORD_W:0]   diff_y;
    rot_stage_t                entry_next;

    logic                      st_valid [NUM_STEPS+1];
    logic                      st_ready [NUM_STEPS+1];
    rot_stage_t                st_data  [NUM_STEPS+1];

    logic                      valid_in_reg;
    rot_stage_t                entry_reg;

    rot_stage_t                last;
    logic signed [PROD_W-1:0]  prod_x_next;
    logic signed [PROD_W-1:0]  prod_y_next;
    logic                      gain_valid_reg;
    logic                      gain_ready;
    logic signed [PROD_W-1:0]  prod_x_reg;
    logic signed [PROD_W-1:0]  prod_y_reg;
    logic [HALF_W-1:0]         gain_hw_reg;
    logic [HALF_W-1:0]         gain_hh_reg;

    logic signed [PROD_W-1:0]  round_x_sum;
    logic signed [PROD_W-1:0]  round_y_sum;
    logic                      round_valid_reg;
    logic                      round_ready;
    logic signed [XY_W-1:0]    round_x_reg;
    logic signed [XY_W-1:0]    round_y_reg;
    logic [HALF_W-1:0]         round_hw_reg;
    logic [HALF_W-1:0]         round_hh_reg;

    logic                      mag_valid_reg;
    logic                      mag_ready;
    logic [XY_W-1:0]           mag_x_reg;
    logic [XY_W-1:0]           mag_y_reg;
    logic [HALF_W-1:0]         mag_hw_reg;
    logic [HALF_W-1:0]         mag_hh_reg;

    logic [XY_W:0]             radius_q8;
    logic [XY_W:0]             reach_x;
    logic [XY_W:0]             reach_y;
    logic [XY_W:0]             hw_q8;
    logic [XY_W:0]             hh_q8;
    logic                      inside_next;
    logic                      out_valid_reg;
    logic                      out_ready;
    logic                      inside_reg;

    // Configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg      <= '0;
            target_y_reg      <= '0;
            target_radius_reg <= RADIUS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TARGET_X:      target_x_reg      <= cfg_data;
                CFG_TARGET_Y:      target_y_reg      <= cfg_data;
                CFG_TARGET_RADIUS: target_radius_reg <= cfg_data[HALF_W-1:0];
                default:           ;
            endcase
        end
    end

    // Input stage: offset, fold past a quarter turn
    assign rect_x      = s_axis_tdata[15:0];
    assign rect_y      = s_axis_tdata[31:16];
    assign rect_angle  = s_axis_tdata[47:32];
    assign half_width  = s_axis_tdata[62:48];
    assign half_height = s_axis_tdata[77:63];

    assign theta = COORD_W'(16'd0 - rect_angle);
    assign fold  = (theta > 16'sd16384) || (theta < -16'sd16384);
    assign z_top = fold ? (theta ^ 16'h8000) : theta;

    always_comb
    begin
        if (fold)
        begin
            diff_x = 17'(rect_x) - 17'(target_x_reg);
            diff_y = 17'(rect_y) - 17'(target_y_reg);
        end
        else
        begin
            diff_x = 17'(target_x_reg) - 17'(rect_x);
            diff_y = 17'(target_y_reg) - 17'(rect_y);
        end
        entry_next.bypass      = (rect_angle == '0);
        entry_next.x           = {(XY_W-FRAC_W)'(diff_x), {FRAC_W{1'b0}}};
        entry_next.y           = {(XY_W-FRAC_W)'(diff_y), {FRAC_W{1'b0}}};
        entry_next.z           = {z_top, {(Z_W-COORD_W){1'b0}}};
        entry_next.half_width  = half_width;
        entry_next.half_height = half_height;
    end

    assign s_axis_tready = !valid_in_reg || st_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_in_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_in_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            entry_reg <= entry_next;
        end
    end

    assign st_valid[0] = valid_in_reg;
    assign st_data[0]  = entry_reg;

    // Rotation pipeline
    for (genvar k = 0; k < NUM_STEPS; k++)
    begin : g_step
        cirt_cordic_stage #(
            .STEP (k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[k]),
            .in_ready  (st_ready[k]),
            .in_data   (st_data[k]),
            .out_valid (st_valid[k+1]),
            .out_ready (st_ready[k+1]),
            .out_data  (st_data[k+1])
        );
    end

    // Gain compensation
    assign last        = st_data[NUM_STEPS];
    assign prod_x_next = last.bypass ? ($signed({last.x[XY_W-1], last.x, {GAIN_SH{1'b0}}}))
                                     : last.x * GAIN_Q30;
    assign prod_y_next = last.bypass ? ($signed({last.y[XY_W-1], last.y, {GAIN_SH{1'b0}}}))
                                     : last.y * GAIN_Q30;

    assign st_ready[NUM_STEPS] = !gain_valid_reg || gain_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_valid_reg <= 1'b0;
        end
        else if (st_ready[NUM_STEPS])
        begin
            gain_valid_reg <= st_valid[NUM_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_ready[NUM_STEPS] && st_valid[NUM_STEPS])
        begin
            prod_x_reg  <= prod_x_next;
            prod_y_reg  <= prod_y_next;
            gain_hw_reg <= last.half_width;
            gain_hh_reg <= last.half_height;
        end
    end

    // Round to nearest, ties up
    assign round_x_sum = prod_x_reg + (PROD_W'(1) <<< (GAIN_SH - 1));
    assign round_y_sum = prod_y_reg + (PROD_W'(1) <<< (GAIN_SH - 1));

    assign gain_ready = !round_valid_reg || round_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_valid_reg <= 1'b0;
        end
        else if (gain_ready)
        begin
            round_valid_reg <= gain_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gain_ready && gain_valid_reg)
        begin
            round_x_reg  <= round_x_sum[GAIN_SH +: XY_W];
            round_y_reg  <= round_y_sum[GAIN_SH +: XY_W];
            round_hw_reg <= gain_hw_reg;
            round_hh_reg <= gain_hh_reg;
        end
    end

    // Magnitude
    assign round_ready = !mag_valid_reg || mag_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg <= 1'b0;
        end
        else if (round_ready)
        begin
            mag_valid_reg <= round_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (round_ready && round_valid_reg)
        begin
            mag_x_reg  <= round_x_reg[XY_W-1] ? XY_W'(-round_x_reg) : XY_W'(round_x_reg);
            mag_y_reg  <= round_y_reg[XY_W-1] ? XY_W'(-round_y_reg) : XY_W'(round_y_reg);
            mag_hw_reg <= round_hw_reg;
            mag_hh_reg <= round_hh_reg;
        end
    end

    // Compare and output register
    assign radius_q8   = (XY_W+1)'({target_radius_reg, {FRAC_W{1'b0}}});
    assign hw_q8       = (XY_W+1)'({mag_hw_reg, {FRAC_W{1'b0}}});
    assign hh_q8       = (XY_W+1)'({mag_hh_reg, {FRAC_W{1'b0}}});
    assign reach_x     = {1'b0, mag_x_reg} + radius_q8;
    assign reach_y     = {1'b0, mag_y_reg} + radius_q8;
    assign inside_next = (reach_x <= hw_q8) && (reach_y <= hh_q8);

    assign mag_ready = !out_valid_reg || out_ready;
    assign out_ready = m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (mag_ready)
        begin
            out_valid_reg <= mag_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mag_ready && mag_valid_reg)
        begin
            inside_reg <= inside_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, inside_reg};

endmodule

>>> rtl/core/cirt_checker.sv
// Port-level checks for the circle-in-rotated-rectangle test, bound to the top
`include "circle_in_rotated_rect_test_macros.svh"

module cirt_checker
    import cirt_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   cfg_valid,
    input logic                   cfg_ready
);

    `CIRT_ASSERT_NEXT(a_out_valid_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output beat dropped while stalled")
    `CIRT_ASSERT_NEXT(a_out_data_holds, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output beat changed while stalled")
    `CIRT_ASSERT_SAME(a_empty_out_accepts, !m_axis_tvalid, s_axis_tready, "input stalled with empty output stage")
    `CIRT_ASSERT_SAME(a_out_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:1] == '0, "output pad bits not zero")
    `CIRT_ASSERT_SAME(a_cfg_always_taken, cfg_valid, cfg_ready, "configuration write not taken")

endmodule

bind circle_in_rotated_rect_test cirt_checker u_cirt_checker (.*);
